@@ hdl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Clocked assertion helpers used by the allocator datapath (ffha_dp).
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_HOLDS(label, clk, rst, !(cond), msg)
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

@@ hdl/ffha_pkg.sv @@
// ============================================================================
// ffha_pkg
// Shared types and fixed field widths of the first-fit heap allocator.
// ============================================================================
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int ADDR_W  = 32;
   localparam int REQ_W   = 16;
   localparam int BYTES_W = 17;
   localparam int COUNT_W = 9;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_INVALID      = 3'd2,
      ST_RANGE        = 3'd3,
      ST_ALREADY_FREE = 3'd4
   } status_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic       load;
      logic       advance;
      logic       take;
      logic       split;
      logic       write_head;
      logic       release_blk;
      logic       restart;
      logic       hold_i;
      logic       merge;
      logic       set_status;
      status_type code;
      logic       emit;
   } ctrl_cmd_type;

   // Flags from the datapath to the sequencer.
   typedef struct packed {
      logic is_free_cmd;
      logic zero_req;
      logic zero_addr;
      logic out_of_range;
      logic fit;
      logic can_split;
      logic last;
      logic match;
      logic in_use;
      logic mergeable;
      logic rsp_busy;
   } dp_stat_type;

endpackage

@@ hdl/ffha_if.sv @@
// ============================================================================
// ffha interfaces
// Valid/ready channels for requests, responses and the base register.
// ============================================================================
`timescale 1ns / 1ps
interface ffha_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [ffha_pkg::REQ_W-1:0]   request_bytes;
   logic [ffha_pkg::ADDR_W-1:0]  free_address;
   modport source (output valid, command, request_bytes, free_address, input ready);
   modport sink   (input valid, command, request_bytes, free_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [ffha_pkg::ADDR_W-1:0]   payload_address;
   logic [ffha_pkg::BYTES_W-1:0]  used_bytes;
   logic [ffha_pkg::BYTES_W-1:0]  idle_bytes;
   logic [ffha_pkg::COUNT_W-1:0]  used_blocks;
   logic [ffha_pkg::COUNT_W-1:0]  idle_blocks;
   modport source (output valid, status, payload_address, used_bytes, idle_bytes,
                   used_blocks, idle_blocks, input ready);
   modport sink   (input valid, status, payload_address, used_bytes, idle_bytes,
                   used_blocks, idle_blocks, output ready);
endinterface

interface ffha_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ffha_pkg::ADDR_W-1:0]  arena_base;
   modport source (output valid, arena_base, input ready);
   modport sink   (input valid, arena_base, output ready);
endinterface

@@ hdl/ffha_ram.sv @@
// ============================================================================
// ffha_ram
// Simple dual-port RAM with one write port and a registered read port.
// ============================================================================
`timescale 1ns / 1ps
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/ffha_ctrl.sv @@
// ============================================================================
// ffha_ctrl
// Sequencer for allocate, free and the coalescing walk.
// ============================================================================
`timescale 1ns / 1ps
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::dp_stat_type  st,
   output ffha_pkg::ctrl_cmd_type cmd
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_ACHK   = 9'b000000010,
      S_AWR    = 9'b000000100,
      S_FCHK   = 9'b000001000,
      S_MSTART = 9'b000010000,
      S_MHEAD  = 9'b000100000,
      S_MCHK   = 9'b001000000,
      S_DONE   = 9'b010000000,
      S_SPARE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ffha_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!st.is_free_cmd) begin
                  if (st.zero_req) begin
                     cmd.set_status = 1'b1;
                     cmd.code       = ffha_pkg::ST_NO_SPACE;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_ACHK;
                  end
               end else if (st.zero_addr) begin
                  cmd.set_status = 1'b1;
                  cmd.code       = ffha_pkg::ST_INVALID;
                  state_in       = S_DONE;
               end else if (st.out_of_range) begin
                  cmd.set_status = 1'b1;
                  cmd.code       = ffha_pkg::ST_RANGE;
                  state_in       = S_DONE;
               end else begin
                  state_in = S_FCHK;
               end
            end
         end
         S_ACHK: begin
            if (st.fit) begin
               cmd.set_status = 1'b1;
               cmd.code       = ffha_pkg::ST_OK;
               if (st.can_split) begin
                  cmd.split = 1'b1;
                  state_in  = S_AWR;
               end else begin
                  cmd.take = 1'b1;
                  state_in = S_DONE;
               end
            end else if (st.last) begin
               cmd.set_status = 1'b1;
               cmd.code       = ffha_pkg::ST_NO_SPACE;
               state_in       = S_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_AWR: begin
            cmd.write_head = 1'b1;
            state_in       = S_DONE;
         end
         S_FCHK: begin
            if (st.match) begin
               if (!st.in_use) begin
                  cmd.set_status = 1'b1;
                  cmd.code       = ffha_pkg::ST_ALREADY_FREE;
                  state_in       = S_DONE;
               end else begin
                  cmd.release_blk = 1'b1;
                  cmd.set_status  = 1'b1;
                  cmd.code        = ffha_pkg::ST_OK;
                  state_in        = S_MSTART;
               end
            end else if (st.last) begin
               cmd.set_status = 1'b1;
               cmd.code       = ffha_pkg::ST_INVALID;
               state_in       = S_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_MSTART: begin
            cmd.restart = 1'b1;
            state_in    = S_MHEAD;
         end
         S_MHEAD: begin
            cmd.hold_i = 1'b1;
            if (st.last) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_MCHK;
            end
         end
         S_MCHK: begin
            if (st.mergeable) begin
               cmd.merge = 1'b1;
            end else begin
               cmd.hold_i = 1'b1;
            end
            if (st.last) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_DONE: begin
            if (!st.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SPARE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ hdl/ffha_dp.sv @@
// ============================================================================
// ffha_dp
// Block table, spare-entry stack, statistics and response registers.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffha_dp #(
   parameter int ARENA_BYTES     = 65536,
   parameter int GRANULE_BYTES   = 16,
   parameter int HEADER_GRANULES = 2,
   parameter int MAX_BLOCKS      = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ffha_pkg::ADDR_W-1:0]       csr_data,
   input  logic                              req_command,
   input  logic [ffha_pkg::REQ_W-1:0]        req_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]       req_address,
   input  ffha_pkg::ctrl_cmd_type            cmd,
   output ffha_pkg::dp_stat_type             st,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]       rsp_address,
   output logic [ffha_pkg::BYTES_W-1:0]      rsp_used_bytes,
   output logic [ffha_pkg::BYTES_W-1:0]      rsp_idle_bytes,
   output logic [ffha_pkg::COUNT_W-1:0]      rsp_used_blocks,
   output logic [ffha_pkg::COUNT_W-1:0]      rsp_idle_blocks
);
   localparam int SH     = $clog2(GRANULE_BYTES);
   localparam int TOTAL  = ARENA_BYTES / GRANULE_BYTES;
   localparam int FIRST  = (TOTAL > HEADER_GRANULES) ? (TOTAL - HEADER_GRANULES) : 0;
   localparam int GW     = $clog2(TOTAL + 1);
   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int NEED_W = ffha_pkg::REQ_W + 1 - SH;
   localparam int BW     = ffha_pkg::BYTES_W;
   localparam int CW     = ffha_pkg::COUNT_W;
   localparam int AW     = ffha_pkg::ADDR_W;

   typedef struct packed {
      logic [GW-1:0]     off;
      logic [GW-1:0]     pay;
      logic [LINK_W-1:0] link;
      logic              used;
   } entry_type;

   localparam int WORD_W = $bits(entry_type);

   logic [AW-1:0]     base_ff, base_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [AW-1:0]     rel_ff, rel_in;
   entry_type         i_ff, i_in;
   logic [IDX_W-1:0]  i_idx_ff, i_idx_in;
   logic [IDX_W-1:0]  s_ff, s_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;
   logic [LINK_W-1:0] sp_ff, sp_in;
   logic              e0_valid_ff, e0_valid_in;
   logic [2:0]        status_ff, status_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [BW-1:0]     ubytes_ff, ubytes_in, ibytes_ff, ibytes_in;
   logic [CW-1:0]     ublk_ff, ublk_in, iblk_ff, iblk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        o_status_ff, o_status_in;
   logic [AW-1:0]     o_addr_ff, o_addr_in;
   logic [BW-1:0]     o_ub_ff, o_ub_in, o_ib_ff, o_ib_in;
   logic [CW-1:0]     o_uk_ff, o_uk_in, o_ik_ff, o_ik_in;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_wa;
   entry_type         ram_wd;
   logic [WORD_W-1:0] ram_rd;
   entry_type         cur_data;
   logic              stk_we;
   logic [IDX_W-1:0]  stk_rd;
   logic [AW-1:0]     start, rel_now, pay_addr;
   logic [ffha_pkg::REQ_W:0] req_round;
   logic              spare_avail, from_fresh;
   logic [IDX_W-1:0]  s_pick;
   logic [BW-1:0]     cur_bytes, need_bytes, head_bytes;
   logic [GW-1:0]     merged_pay;

   ffha_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BLOCKS)) u_tbl (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (cur_in[IDX_W-1:0]),
      .rd_data (ram_rd)
   );

   ffha_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[IDX_W-1:0]),
      .wr_data (cur_ff[IDX_W-1:0]),
      .rd_addr (IDX_W'(sp_ff - 1'b1)),
      .rd_data (stk_rd)
   );

   always_comb begin
      // Entry 0 reads as the initial arena-wide free block until first written.
      if (cur_ff == '0 && !e0_valid_ff) begin
         cur_data      = '0;
         cur_data.pay  = GW'(FIRST);
         cur_data.link = LINK_W'(MAX_BLOCKS);
      end else begin
         cur_data = entry_type'(ram_rd);
      end
   end

   assign start       = {base_ff[AW-1:SH], {SH{1'b0}}};
   assign rel_now     = req_address - start;
   assign req_round   = {1'b0, req_bytes} + (ffha_pkg::REQ_W+1)'(GRANULE_BYTES - 1);
   assign pay_addr    = start + ((AW'(cur_data.off) + AW'(HEADER_GRANULES)) << SH);
   assign from_fresh  = (fresh_ff != LINK_W'(MAX_BLOCKS));
   assign spare_avail = from_fresh || (sp_ff != '0);
   assign s_pick      = from_fresh ? fresh_ff[IDX_W-1:0] : stk_rd;
   assign cur_bytes   = BW'(AW'(cur_data.pay) << SH);
   assign need_bytes  = BW'(AW'(need_ff) << SH);
   assign head_bytes  = BW'(AW'(HEADER_GRANULES) << SH);
   assign merged_pay  = i_ff.pay + GW'(HEADER_GRANULES) + cur_data.pay;

   always_comb begin
      st.is_free_cmd  = req_command;
      st.zero_req     = (req_bytes == '0);
      st.zero_addr    = (req_address == '0);
      st.out_of_range = (rel_now < AW'(HEADER_GRANULES * GRANULE_BYTES))
                     || (rel_now >= AW'(TOTAL * GRANULE_BYTES));
      st.fit          = !cur_data.used && (AW'(cur_data.pay) >= AW'(need_ff));
      st.can_split    = spare_avail && (AW'(cur_data.pay) >=
                        AW'(need_ff) + AW'(HEADER_GRANULES) + AW'(1));
      st.last         = (cur_data.link == LINK_W'(MAX_BLOCKS));
      st.match        = ((AW'(cur_data.off) + AW'(HEADER_GRANULES)) << SH) == rel_ff;
      st.in_use       = cur_data.used;
      st.mergeable    = !i_ff.used && !cur_data.used && ((AW'(i_ff.off)
                        + AW'(HEADER_GRANULES) + AW'(i_ff.pay)) == AW'(cur_data.off));
      st.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      base_in      = csr_we ? csr_data : base_ff;
      cur_in       = cur_ff;
      need_in      = need_ff;
      rel_in       = rel_ff;
      i_in         = i_ff;
      i_idx_in     = i_idx_ff;
      s_in         = s_ff;
      fresh_in     = fresh_ff;
      sp_in        = sp_ff;
      status_in    = cmd.set_status ? cmd.code : status_ff;
      addr_in      = addr_ff;
      ubytes_in    = ubytes_ff;
      ibytes_in    = ibytes_ff;
      ublk_in      = ublk_ff;
      iblk_in      = iblk_ff;
      ram_we       = 1'b0;
      ram_wa       = cur_ff[IDX_W-1:0];
      ram_wd       = cur_data;
      stk_we       = 1'b0;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.emit;
      o_status_in  = o_status_ff;
      o_addr_in    = o_addr_ff;
      o_ub_in      = o_ub_ff;
      o_ib_in      = o_ib_ff;
      o_uk_in      = o_uk_ff;
      o_ik_in      = o_ik_ff;

      if (cmd.load) begin
         cur_in  = '0;
         need_in = NEED_W'(req_round >> SH);
         rel_in  = rel_now;
         addr_in = '0;
      end
      if (cmd.restart) begin
         cur_in = '0;
      end
      if (cmd.advance) begin
         cur_in = cur_data.link;
      end
      if (cmd.take) begin
         ram_we       = 1'b1;
         ram_wd.used  = 1'b1;
         addr_in      = pay_addr;
         ubytes_in    = ubytes_ff + cur_bytes;
         ibytes_in    = ibytes_ff - cur_bytes;
         ublk_in      = ublk_ff + 1'b1;
         iblk_in      = iblk_ff - 1'b1;
      end
      if (cmd.split) begin
         ram_we      = 1'b1;
         ram_wa      = s_pick;
         ram_wd.off  = cur_data.off + GW'(HEADER_GRANULES) + GW'(need_ff);
         ram_wd.pay  = cur_data.pay - GW'(need_ff) - GW'(HEADER_GRANULES);
         ram_wd.link = cur_data.link;
         ram_wd.used = 1'b0;
         i_in        = cur_data;
         i_idx_in    = cur_ff[IDX_W-1:0];
         s_in        = s_pick;
         addr_in     = pay_addr;
         ubytes_in   = ubytes_ff + need_bytes;
         ibytes_in   = ibytes_ff - need_bytes - head_bytes;
         ublk_in     = ublk_ff + 1'b1;
         if (from_fresh) begin
            fresh_in = fresh_ff + 1'b1;
         end else begin
            sp_in = sp_ff - 1'b1;
         end
      end
      if (cmd.write_head) begin
         ram_we      = 1'b1;
         ram_wa      = i_idx_ff;
         ram_wd.off  = i_ff.off;
         ram_wd.pay  = GW'(need_ff);
         ram_wd.link = LINK_W'(s_ff);
         ram_wd.used = 1'b1;
      end
      if (cmd.release_blk) begin
         ram_we      = 1'b1;
         ram_wd.used = 1'b0;
         ubytes_in   = ubytes_ff - cur_bytes;
         ibytes_in   = ibytes_ff + cur_bytes;
         ublk_in     = ublk_ff - 1'b1;
         iblk_in     = iblk_ff + 1'b1;
      end
      if (cmd.hold_i) begin
         i_in     = cur_data;
         i_idx_in = cur_ff[IDX_W-1:0];
      end
      if (cmd.merge) begin
         // Absorb the current block into the held one and recycle its entry.
         ram_we      = 1'b1;
         ram_wa      = i_idx_ff;
         ram_wd.off  = i_ff.off;
         ram_wd.pay  = merged_pay;
         ram_wd.link = cur_data.link;
         ram_wd.used = i_ff.used;
         i_in.pay    = merged_pay;
         i_in.link   = cur_data.link;
         stk_we      = 1'b1;
         sp_in       = sp_ff + 1'b1;
         ibytes_in   = ibytes_ff + head_bytes;
         iblk_in     = iblk_ff - 1'b1;
      end
      if (cmd.emit) begin
         o_status_in = status_ff;
         o_addr_in   = addr_ff;
         o_ub_in     = ubytes_ff;
         o_ib_in     = ibytes_ff;
         o_uk_in     = ublk_ff;
         o_ik_in     = iblk_ff;
      end
      e0_valid_in = e0_valid_ff || (ram_we && ram_wa == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         fresh_ff     <= LINK_W'(1);
         sp_ff        <= '0;
         e0_valid_ff  <= 1'b0;
         ubytes_ff    <= '0;
         ibytes_ff    <= BW'(AW'(FIRST) << SH);
         ublk_ff      <= '0;
         iblk_ff      <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         fresh_ff     <= fresh_in;
         sp_ff        <= sp_in;
         e0_valid_ff  <= e0_valid_in;
         ubytes_ff    <= ubytes_in;
         ibytes_ff    <= ibytes_in;
         ublk_ff      <= ublk_in;
         iblk_ff      <= iblk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      need_ff     <= need_in;
      rel_ff      <= rel_in;
      i_ff        <= i_in;
      i_idx_ff    <= i_idx_in;
      s_ff        <= s_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
      o_status_ff <= o_status_in;
      o_addr_ff   <= o_addr_in;
      o_ub_ff     <= o_ub_in;
      o_ib_ff     <= o_ib_in;
      o_uk_ff     <= o_uk_in;
      o_ik_ff     <= o_ik_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_address     = o_addr_ff;
   assign rsp_used_bytes  = o_ub_ff;
   assign rsp_idle_bytes  = o_ib_ff;
   assign rsp_used_blocks = o_uk_ff;
   assign rsp_idle_blocks = o_ik_ff;

   // Live blocks equal entries handed out minus entries recycled.
   `ASSERT_HOLDS(block_count_tracks_entries, clock, reset,
      (ublk_ff + iblk_ff) == CW'(fresh_ff - sp_ff), "block counts disagree with table use")
   `ASSERT_NEVER(stack_overflow, clock, reset,
      sp_ff > LINK_W'(MAX_BLOCKS - 1), "spare stack overflow")
   `ASSERT_NEVER(split_onto_self, clock, reset,
      cmd.split && (s_pick == cur_ff[IDX_W-1:0]), "split entry equals the split block")
endmodule

@@ hdl/first_fit_heap_allocator_unit.sv @@
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit heap allocator with block split and free-block coalescing.
// ============================================================================
// Usage: the req channel carries one command word (allocate or free). The
// block answers each word with exactly one word on the rsp channel, holding
// the status, the granted payload address and the arena statistics after
// the operation. The csr channel writes the arena base address; it is
// always ready and must only be written while no command is outstanding.
// Walks: an allocate walks the block list at one block per cycle; a free
// walks to its block and then runs a coalescing pass over the whole list.
// The table RAM has a single read port, one entry read per cycle.
// Rejected commands (zero size, zero or out-of-range address) go to the
// response without a walk. Only one command is worked on at a time: a new
// command is accepted only once the previous response has been emitted.
// Reset leaves the arena as one free block covering all granules but one
// header; the table RAM needs no clearing pass. A stalled rsp channel holds
// its word in the output register; the next command can be accepted and
// worked on, and it waits for the output register only when finished.
// ============================================================================
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit #(
   parameter int ARENA_BYTES     = 65536,
   parameter int GRANULE_BYTES   = 16,
   parameter int HEADER_GRANULES = 2,
   parameter int MAX_BLOCKS      = 256
) (
   input  logic         clock,
   input  logic         reset,
   ffha_req_if.sink     req_ch,
   ffha_rsp_if.source   rsp_ch,
   ffha_csr_if.sink     csr_ch
);
   ffha_pkg::ctrl_cmd_type cmd;
   ffha_pkg::dp_stat_type  st;
   logic                   req_ready;

   // The base register accepts a word on every cycle.
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   ffha_dp #(
      .ARENA_BYTES     (ARENA_BYTES),
      .GRANULE_BYTES   (GRANULE_BYTES),
      .HEADER_GRANULES (HEADER_GRANULES),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_ch.valid),
      .csr_data        (csr_ch.arena_base),
      .req_command     (req_ch.command),
      .req_bytes       (req_ch.request_bytes),
      .req_address     (req_ch.free_address),
      .cmd             (cmd),
      .st              (st),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_address     (rsp_ch.payload_address),
      .rsp_used_bytes  (rsp_ch.used_bytes),
      .rsp_idle_bytes  (rsp_ch.idle_bytes),
      .rsp_used_blocks (rsp_ch.used_blocks),
      .rsp_idle_blocks (rsp_ch.idle_blocks)
   );
endmodule
